// ===== hw/rtl/hwb_pkg.sv =====
// ----------------------------------------------------------------------------
// hwb_pkg: shared types and constants of the heartbeat watchdog
// Holds the count width, the command and register codes, the request,
// result and configuration records, and small width helpers.
// ----------------------------------------------------------------------------
package hwb_pkg;

  // Width of the countdowns and of the check interval (8 to 32)
  localparam int CNT_W = 16;
  // Width of the configuration registers, fixed by the register map
  localparam int CFG_W = 16;
  // Wide enough for a doubled interval and for any register value
  localparam int WIDE_W = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;

  localparam logic [WIDE_W-1:0] CNT_MAX_W = {{(WIDE_W-CNT_W){1'b0}}, {CNT_W{1'b1}}};
  localparam logic [CNT_W-1:0]  CNT_ONE   = {{(CNT_W-1){1'b0}}, 1'b1};
  localparam logic [CNT_W-1:0]  CNT_ZERO  = '0;

  // Command codes
  localparam logic [2:0] CMD_TICK       = 3'd0;
  localparam logic [2:0] CMD_UPDATE     = 3'd1;
  localparam logic [2:0] CMD_PONG       = 3'd2;
  localparam logic [2:0] CMD_TERMINATED = 3'd3;
  localparam logic [2:0] CMD_INVALIDATE = 3'd4;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_INTERVAL     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLY_TIMEOUT    = 2'd2;

  // Register reset values: 20 s, 8 h, 90 s at one tick per second
  localparam logic [CFG_W-1:0] RST_INITIAL_INTERVAL = 16'd20;
  localparam logic [CFG_W-1:0] RST_MAX_INTERVAL     = 16'd28800;
  localparam logic [CFG_W-1:0] RST_REPLY_TIMEOUT    = 16'd90;

  typedef struct packed {
    logic [2:0] cmd;
    logic       should_be_active;
    logic       partner_suspended;
    logic       may_go_unresponsive;
  } hwb_req_t;

  typedef struct packed {
    logic responsive;
    logic send_ping;
    logic became_responsive;
    logic became_unresponsive;
  } hwb_res_t;

  typedef struct packed {
    logic [CFG_W-1:0] initial_interval;
    logic [CFG_W-1:0] max_interval;
    logic [CFG_W-1:0] reply_timeout;
  } hwb_cfg_t;

  // Zero-extend a register value to the wide compare width
  function automatic logic [WIDE_W-1:0] cfg_wide(input logic [CFG_W-1:0] v);
    return {{(WIDE_W-CFG_W){1'b0}}, v};
  endfunction

  // Fit a register value into a countdown (keeps the low CNT_W bits)
  function automatic logic [CNT_W-1:0] cfg_fit(input logic [CFG_W-1:0] v);
    logic [WIDE_W-1:0] w;
    w = cfg_wide(v);
    return w[CNT_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/hwb_if.sv =====
// ----------------------------------------------------------------------------
// hwb_in_if / hwb_out_if: request and result channels
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface hwb_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic       should_be_active;
  logic       partner_suspended;
  logic       may_go_unresponsive;

  modport source (output valid, cmd, should_be_active, partner_suspended,
                  may_go_unresponsive, input ready);
  modport sink   (input valid, cmd, should_be_active, partner_suspended,
                  may_go_unresponsive, output ready);
endinterface

interface hwb_out_if;
  logic valid;
  logic ready;
  logic responsive;
  logic send_ping;
  logic became_responsive;
  logic became_unresponsive;

  modport source (output valid, responsive, send_ping, became_responsive,
                  became_unresponsive, input ready);
  modport sink   (input valid, responsive, send_ping, became_responsive,
                  became_unresponsive, output ready);
endinterface

// ===== hw/rtl/heartbeat_watchdog_backoff_unit.sv =====
// ----------------------------------------------------------------------------
// heartbeat_watchdog_backoff_unit: heartbeat watchdog with exponential backoff
// Request register, state update, result register, configuration registers.
// ----------------------------------------------------------------------------
//
//  Channel  | Dir | Handshake        | Payload
//  ---------+-----+------------------+-----------------------------------------
//  in_chan  | in  | valid / ready    | cmd, should_be_active, partner_suspended,
//           |     |                  | may_go_unresponsive
//  out_chan | out | valid / ready    | responsive, send_ping, became_responsive,
//           |     |                  | became_unresponsive
//  cfg_*    | in  | cfg_we (no wait) | cfg_idx, cfg_wdata
//
//  One request per cycle sustained unless out_chan stalls; every request yields
//  one result, through the request register and then the result register.
//  The state update is a single decrement, compare and doubling between them.
//  Reset is synchronous on rst_n; no clearing pass.
//  A stalled result holds the result register; the request register keeps
//  taking one more request, then in_chan.ready drops until out_chan drains.
//
module heartbeat_watchdog_backoff_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  hwb_in_if.sink                        in_chan,
  hwb_out_if.source                     out_chan,
  input  logic                          cfg_we,
  input  logic [hwb_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [hwb_pkg::CFG_W-1:0]     cfg_wdata
);

  // Configuration registers
  hwb_pkg::hwb_cfg_t cfg_r;

  // Request register
  logic              req_valid_r, req_valid_nxt;
  hwb_pkg::hwb_req_t req_r;

  // Result register
  logic              res_valid_r, res_valid_nxt;
  hwb_pkg::hwb_res_t res_r;
  hwb_pkg::hwb_res_t core_res;

  logic in_take;
  logic advance;

  // Advance the request into the state when the result register is free
  assign advance       = !res_valid_r || out_chan.ready;
  assign in_chan.ready = !req_valid_r || advance;
  assign in_take       = in_chan.valid && in_chan.ready;

  always_comb begin
    req_valid_nxt = req_valid_r;
    if (in_take) begin
      req_valid_nxt = 1'b1;
    end else if (advance) begin
      req_valid_nxt = 1'b0;
    end
    res_valid_nxt = res_valid_r;
    if (req_valid_r && advance) begin
      res_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      res_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      req_valid_r <= req_valid_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  // Capture the request payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      req_r.cmd                 <= in_chan.cmd;
      req_r.should_be_active    <= in_chan.should_be_active;
      req_r.partner_suspended   <= in_chan.partner_suspended;
      req_r.may_go_unresponsive <= in_chan.may_go_unresponsive;
    end
  end

  // Latch the result as the state moves
  always_ff @(posedge clk) begin
    if (req_valid_r && advance) begin
      res_r <= core_res;
    end
  end

  // Register writes; an index past the map is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.initial_interval <= hwb_pkg::RST_INITIAL_INTERVAL;
      cfg_r.max_interval     <= hwb_pkg::RST_MAX_INTERVAL;
      cfg_r.reply_timeout    <= hwb_pkg::RST_REPLY_TIMEOUT;
    end else if (cfg_we) begin
      case (cfg_idx)
        hwb_pkg::CFG_INITIAL_INTERVAL: cfg_r.initial_interval <= cfg_wdata;
        hwb_pkg::CFG_MAX_INTERVAL:     cfg_r.max_interval     <= cfg_wdata;
        hwb_pkg::CFG_REPLY_TIMEOUT:    cfg_r.reply_timeout    <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  hwb_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (req_valid_r && advance),
    .req   (req_r),
    .cfg   (cfg_r),
    .res   (core_res)
  );

  assign out_chan.valid               = res_valid_r;
  assign out_chan.responsive          = res_r.responsive;
  assign out_chan.send_ping           = res_r.send_ping;
  assign out_chan.became_responsive   = res_r.became_responsive;
  assign out_chan.became_unresponsive = res_r.became_unresponsive;

endmodule

// ===== hw/rtl/hwb_core.sv =====
// ----------------------------------------------------------------------------
// hwb_core: watchdog state and per-request update
// Holds the countdowns, interval and responsive flag; applies one request
// when enabled and presents its result combinationally.
// ----------------------------------------------------------------------------
module hwb_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  hwb_pkg::hwb_req_t req,
  input  hwb_pkg::hwb_cfg_t cfg,
  output hwb_pkg::hwb_res_t res
);

  logic                      chk_armed_r, chk_armed_nxt;
  logic [hwb_pkg::CNT_W-1:0] chk_cnt_r, chk_cnt_nxt;
  logic                      to_armed_r, to_armed_nxt;
  logic [hwb_pkg::CNT_W-1:0] to_cnt_r, to_cnt_nxt;
  logic [hwb_pkg::CNT_W-1:0] interval_r, interval_nxt;
  logic                      resp_r, resp_nxt;

  logic [hwb_pkg::WIDE_W-1:0] dbl_w;
  logic [hwb_pkg::WIDE_W-1:0] dbl_sat;
  logic [hwb_pkg::CNT_W-1:0]  dbl;
  logic                       ping, note_up, note_down;

  // Doubled interval, capped at max_interval and at the count range
  always_comb begin
    dbl_w = '0;
    dbl_w[hwb_pkg::CNT_W:1] = interval_r;
    dbl_sat = dbl_w;
    if (dbl_sat > hwb_pkg::cfg_wide(cfg.max_interval)) begin
      dbl_sat = hwb_pkg::cfg_wide(cfg.max_interval);
    end
    if (dbl_sat > hwb_pkg::CNT_MAX_W) begin
      dbl_sat = hwb_pkg::CNT_MAX_W;
    end
    dbl = dbl_sat[hwb_pkg::CNT_W-1:0];
  end

  always_comb begin
    chk_armed_nxt = chk_armed_r;
    chk_cnt_nxt   = chk_cnt_r;
    to_armed_nxt  = to_armed_r;
    to_cnt_nxt    = to_cnt_r;
    interval_nxt  = interval_r;
    resp_nxt      = resp_r;
    ping          = 1'b0;
    note_up       = 1'b0;
    note_down     = 1'b0;
    case (req.cmd)
      hwb_pkg::CMD_TICK: begin
        if (to_armed_r) begin
          if (to_cnt_r <= hwb_pkg::CNT_ONE) begin
            // Reply window closed: back off and rearm the check
            to_cnt_nxt    = hwb_pkg::CNT_ZERO;
            to_armed_nxt  = 1'b0;
            interval_nxt  = dbl;
            chk_armed_nxt = 1'b1;
            chk_cnt_nxt   = dbl;
            if (!req.partner_suspended && resp_r && req.may_go_unresponsive) begin
              resp_nxt  = 1'b0;
              note_down = 1'b1;
            end
          end else begin
            to_cnt_nxt = to_cnt_r - hwb_pkg::CNT_ONE;
          end
        end else if (chk_armed_r) begin
          if (chk_cnt_r <= hwb_pkg::CNT_ONE) begin
            chk_cnt_nxt   = hwb_pkg::CNT_ZERO;
            chk_armed_nxt = 1'b0;
            to_armed_nxt  = 1'b1;
            to_cnt_nxt    = hwb_pkg::cfg_fit(cfg.reply_timeout);
            ping          = 1'b1;
          end else begin
            chk_cnt_nxt = chk_cnt_r - hwb_pkg::CNT_ONE;
          end
        end
      end
      hwb_pkg::CMD_UPDATE: begin
        if (!req.should_be_active) begin
          if (chk_armed_r) begin
            interval_nxt  = hwb_pkg::cfg_fit(cfg.initial_interval);
            chk_armed_nxt = 1'b0;
            chk_cnt_nxt   = hwb_pkg::CNT_ZERO;
          end
          to_armed_nxt = 1'b0;
          to_cnt_nxt   = hwb_pkg::CNT_ZERO;
          resp_nxt     = 1'b1;
        end else if (!chk_armed_r && !to_armed_r) begin
          chk_armed_nxt = 1'b1;
          chk_cnt_nxt   = interval_r;
        end
      end
      hwb_pkg::CMD_PONG: begin
        if (to_armed_r) begin
          to_armed_nxt  = 1'b0;
          to_cnt_nxt    = hwb_pkg::CNT_ZERO;
          interval_nxt  = dbl;
          chk_armed_nxt = 1'b1;
          chk_cnt_nxt   = dbl;
          resp_nxt      = 1'b1;
          note_up       = !resp_r;
        end
      end
      hwb_pkg::CMD_TERMINATED: begin
        to_armed_nxt  = 1'b0;
        to_cnt_nxt    = hwb_pkg::CNT_ZERO;
        chk_armed_nxt = 1'b0;
        chk_cnt_nxt   = hwb_pkg::CNT_ZERO;
        resp_nxt      = 1'b1;
        note_up       = !resp_r;
      end
      hwb_pkg::CMD_INVALIDATE: begin
        to_armed_nxt  = 1'b0;
        to_cnt_nxt    = hwb_pkg::CNT_ZERO;
        chk_armed_nxt = 1'b0;
        chk_cnt_nxt   = hwb_pkg::CNT_ZERO;
      end
      default: begin
      end
    endcase
  end

  assign res.responsive          = resp_nxt;
  assign res.send_ping           = ping;
  assign res.became_responsive   = note_up;
  assign res.became_unresponsive = note_down;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_armed_r <= 1'b0;
      chk_cnt_r   <= hwb_pkg::CNT_ZERO;
      to_armed_r  <= 1'b0;
      to_cnt_r    <= hwb_pkg::CNT_ZERO;
      interval_r  <= hwb_pkg::cfg_fit(hwb_pkg::RST_INITIAL_INTERVAL);
      resp_r      <= 1'b1;
    end else if (en) begin
      chk_armed_r <= chk_armed_nxt;
      chk_cnt_r   <= chk_cnt_nxt;
      to_armed_r  <= to_armed_nxt;
      to_cnt_r    <= to_cnt_nxt;
      interval_r  <= interval_nxt;
      resp_r      <= resp_nxt;
    end
  end

endmodule

// ===== hw/rtl/hwb_checker.sv =====
// ----------------------------------------------------------------------------
// hwb_checker: port-level checks of the heartbeat watchdog
// Watches the result channel; attached to the top level by bind.
// ----------------------------------------------------------------------------
module hwb_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic responsive,
  input logic send_ping,
  input logic became_responsive,
  input logic became_unresponsive
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(responsive) && $stable(send_ping) &&
      $stable(became_responsive) && $stable(became_unresponsive))
    else $error("stalled result changed");

  // A notice must agree with the flag it reports
  a_note_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!became_responsive || responsive) &&
                  (!became_unresponsive || !responsive))
    else $error("notice disagrees with responsive flag");

  // A ping comes only from check expiry, which carries no notice
  a_ping_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && send_ping |-> !became_responsive && !became_unresponsive)
    else $error("notice together with ping");

endmodule

bind heartbeat_watchdog_backoff_unit hwb_checker u_hwb_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_chan.valid),
  .out_ready           (out_chan.ready),
  .responsive          (out_chan.responsive),
  .send_ping           (out_chan.send_ping),
  .became_responsive   (out_chan.became_responsive),
  .became_unresponsive (out_chan.became_unresponsive)
);

// ===== bench/heartbeat_watchdog_backoff_unit_test.sv =====
// ----------------------------------------------------------------------------
// heartbeat_watchdog_backoff_unit_test: self-checking bench of the watchdog
// Drives commands into the request channel and checks each result against a
// cycle-free model of the countdowns, the backoff and the responsive flag.
// A directed opener walks the ping, timeout, pong and teardown paths. Random
// phases then run under several register settings and handshake pressures.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module heartbeat_watchdog_backoff_unit_test;

  // Abort when no request or result moves for this many cycles
  localparam int unsigned QUIET_LIMIT = 2000;
  // Two register stages inside the block; allow a margin at the end
  localparam int unsigned SETTLE_CYCLES = 8;

  // Tracks the watchdog state and holds the results still owed by the block
  class watchdog_tracker;
    logic [hwb_pkg::CFG_W-1:0] initial_ticks;
    logic [hwb_pkg::CFG_W-1:0] ceiling_ticks;
    logic [hwb_pkg::CFG_W-1:0] reply_ticks;
    bit                        check_armed;
    bit                        timeout_armed;
    bit                        responsive_now;
    logic [hwb_pkg::CNT_W-1:0] check_left;
    logic [hwb_pkg::CNT_W-1:0] timeout_left;
    logic [hwb_pkg::CNT_W-1:0] interval_now;
    hwb_pkg::hwb_res_t         expected_reports[$];
    int unsigned               mismatches;
    int unsigned               seen_reports;

    function new();
      initial_ticks  = hwb_pkg::RST_INITIAL_INTERVAL;
      ceiling_ticks  = hwb_pkg::RST_MAX_INTERVAL;
      reply_ticks    = hwb_pkg::RST_REPLY_TIMEOUT;
      check_armed    = 1'b0;
      timeout_armed  = 1'b0;
      responsive_now = 1'b1;
      check_left     = '0;
      timeout_left   = '0;
      interval_now   = hwb_pkg::cfg_fit(hwb_pkg::RST_INITIAL_INTERVAL);
      mismatches     = 0;
      seen_reports   = 0;
    endfunction

    function void write_reg(logic [hwb_pkg::CFG_IDX_W-1:0] idx,
                            logic [hwb_pkg::CFG_W-1:0] value);
      case (idx)
        hwb_pkg::CFG_INITIAL_INTERVAL: initial_ticks = value;
        hwb_pkg::CFG_MAX_INTERVAL:     ceiling_ticks = value;
        hwb_pkg::CFG_REPLY_TIMEOUT:    reply_ticks   = value;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_reports.size();
    endfunction

    // Double the interval, clip to the ceiling and the counter range, rearm
    function void back_off();
      logic [32:0] doubled;
      logic [32:0] count_top;
      count_top = (33'd1 << hwb_pkg::CNT_W) - 33'd1;
      doubled   = 33'(interval_now) << 1;
      if (doubled > 33'(ceiling_ticks))
        doubled = 33'(ceiling_ticks);
      if (doubled > count_top)
        doubled = count_top;
      interval_now = doubled[hwb_pkg::CNT_W-1:0];
      check_armed  = 1'b1;
      check_left   = interval_now;
    endfunction

    function void note_request(hwb_pkg::hwb_req_t req);
      hwb_pkg::hwb_res_t want;
      want = '0;
      case (req.cmd)
        hwb_pkg::CMD_TICK: begin
          if (timeout_armed) begin
            if (timeout_left <= hwb_pkg::CNT_ONE) begin
              timeout_left  = '0;
              timeout_armed = 1'b0;
              back_off();
              if (!req.partner_suspended && req.may_go_unresponsive && responsive_now) begin
                responsive_now           = 1'b0;
                want.became_unresponsive = 1'b1;
              end
            end else begin
              timeout_left = timeout_left - hwb_pkg::CNT_ONE;
            end
          end else if (check_armed) begin
            if (check_left <= hwb_pkg::CNT_ONE) begin
              check_left     = '0;
              check_armed    = 1'b0;
              timeout_armed  = 1'b1;
              timeout_left   = hwb_pkg::cfg_fit(reply_ticks);
              want.send_ping = 1'b1;
            end else begin
              check_left = check_left - hwb_pkg::CNT_ONE;
            end
          end
        end
        hwb_pkg::CMD_UPDATE: begin
          if (!req.should_be_active) begin
            if (check_armed) begin
              interval_now = hwb_pkg::cfg_fit(initial_ticks);
              check_armed  = 1'b0;
              check_left   = '0;
            end
            timeout_armed  = 1'b0;
            timeout_left   = '0;
            responsive_now = 1'b1;
          end else if (!check_armed && !timeout_armed) begin
            check_armed = 1'b1;
            check_left  = interval_now;
          end
        end
        hwb_pkg::CMD_PONG: begin
          if (timeout_armed) begin
            timeout_armed = 1'b0;
            timeout_left  = '0;
            back_off();
            if (!responsive_now) begin
              responsive_now         = 1'b1;
              want.became_responsive = 1'b1;
            end
          end
        end
        hwb_pkg::CMD_TERMINATED, hwb_pkg::CMD_INVALIDATE: begin
          timeout_armed = 1'b0;
          timeout_left  = '0;
          check_armed   = 1'b0;
          check_left    = '0;
          if (req.cmd == hwb_pkg::CMD_TERMINATED && !responsive_now) begin
            responsive_now         = 1'b1;
            want.became_responsive = 1'b1;
          end
        end
        default: ;
      endcase
      want.responsive = responsive_now;
      expected_reports.push_back(want);
    endfunction

    task log_mismatch(string msg);
      $display("tb: result %0d: %s", seen_reports, msg);
      mismatches++;
    endtask

    task check_report(hwb_pkg::hwb_res_t got);
      hwb_pkg::hwb_res_t want;
      seen_reports++;
      if (expected_reports.size() == 0) begin
        log_mismatch($sformatf("result %b with nothing pending", got));
        return;
      end
      want = expected_reports.pop_front();
      if (got.responsive !== want.responsive)
        log_mismatch($sformatf("responsive expected %b got %b",
                               want.responsive, got.responsive));
      if (got.send_ping !== want.send_ping)
        log_mismatch($sformatf("send_ping expected %b got %b",
                               want.send_ping, got.send_ping));
      if (got.became_responsive !== want.became_responsive)
        log_mismatch($sformatf("became_responsive expected %b got %b",
                               want.became_responsive, got.became_responsive));
      if (got.became_unresponsive !== want.became_unresponsive)
        log_mismatch($sformatf("became_unresponsive expected %b got %b",
                               want.became_unresponsive, got.became_unresponsive));
    endtask
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          cfg_we;
  logic [hwb_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [hwb_pkg::CFG_W-1:0]     cfg_wdata;

  hwb_in_if  in_chan ();
  hwb_out_if out_chan ();

  watchdog_tracker tracker;
  int unsigned     send_idle_pct = 0;
  int unsigned     stall_pct = 0;
  int unsigned     quiet_cycles = 0;

  heartbeat_watchdog_backoff_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // 12 ns clock
  always #6 clk = ~clk;

  // Result side: drop ready at random, updated on the falling edge only
  always @(negedge clk) begin
    out_chan.ready = ($urandom_range(99) >= stall_pct);
  end

  // Sample both channels at the rising edge. Feed accepted requests to the
  // tracker before checking results so a short path cannot race the model.
  // Count quiet cycles and abort when traffic stops for too long.
  always @(posedge clk) begin : monitor
    bit                moved;
    hwb_pkg::hwb_req_t taken;
    hwb_pkg::hwb_res_t got;
    moved = 1'b0;
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready) begin
        taken.cmd                 = in_chan.cmd;
        taken.should_be_active    = in_chan.should_be_active;
        taken.partner_suspended   = in_chan.partner_suspended;
        taken.may_go_unresponsive = in_chan.may_go_unresponsive;
        tracker.note_request(taken);
        moved = 1'b1;
      end
      if (out_chan.valid && out_chan.ready) begin
        got.responsive          = out_chan.responsive;
        got.send_ping           = out_chan.send_ping;
        got.became_responsive   = out_chan.became_responsive;
        got.became_unresponsive = out_chan.became_unresponsive;
        tracker.check_report(got);
        moved = 1'b1;
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic hwb_pkg::hwb_req_t make_req(logic [2:0] cmd, logic active,
                                                 logic suspended, logic may_drop);
    hwb_pkg::hwb_req_t req;
    req.cmd                 = cmd;
    req.should_be_active    = active;
    req.partner_suspended   = suspended;
    req.may_go_unresponsive = may_drop;
    return req;
  endfunction

  // Bias toward ticks so countdowns expire, answer pings often while the
  // timeout runs, and rearm when idle; keep some teardown and junk codes.
  function automatic hwb_pkg::hwb_req_t random_req();
    hwb_pkg::hwb_req_t req;
    int unsigned       pick;
    req = make_req(hwb_pkg::CMD_TICK, 1'($urandom_range(1)), 1'($urandom_range(1)),
                   1'($urandom_range(1)));
    pick = $urandom_range(99);
    if (tracker.timeout_armed && pick < 25) begin
      req.cmd = hwb_pkg::CMD_PONG;
    end else if (!tracker.check_armed && !tracker.timeout_armed && pick < 40) begin
      req.cmd              = hwb_pkg::CMD_UPDATE;
      req.should_be_active = 1'b1;
    end else begin
      pick = $urandom_range(99);
      if (pick < 55)
        req.cmd = hwb_pkg::CMD_TICK;
      else if (pick < 70) begin
        req.cmd              = hwb_pkg::CMD_UPDATE;
        req.should_be_active = ($urandom_range(99) < 70);
      end else if (pick < 78)
        req.cmd = hwb_pkg::CMD_PONG;
      else if (pick < 85)
        req.cmd = hwb_pkg::CMD_TERMINATED;
      else if (pick < 92)
        req.cmd = hwb_pkg::CMD_INVALIDATE;
      else
        req.cmd = 3'($urandom_range(7, 5));
    end
    return req;
  endfunction

  // Offer one request, idling first at the sender's rate; hold until taken.
  // Enter and leave on a falling edge.
  task automatic send_req(input hwb_pkg::hwb_req_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid = 1'b0;
      @(negedge clk);
    end
    in_chan.valid               = 1'b1;
    in_chan.cmd                 = req.cmd;
    in_chan.should_be_active    = req.should_be_active;
    in_chan.partner_suspended   = req.partner_suspended;
    in_chan.may_go_unresponsive = req.may_go_unresponsive;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop offering and wait until every owed result has come back
  task automatic wait_drained();
    in_chan.valid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Write all three registers while the block is idle; mirror them
  task automatic program_regs(input logic [hwb_pkg::CFG_W-1:0] first_ticks,
                              input logic [hwb_pkg::CFG_W-1:0] top_ticks,
                              input logic [hwb_pkg::CFG_W-1:0] wait_ticks);
    logic [hwb_pkg::CFG_W-1:0]     values[3];
    logic [hwb_pkg::CFG_IDX_W-1:0] idxs[3];
    values = '{first_ticks, top_ticks, wait_ticks};
    idxs   = '{hwb_pkg::CFG_INITIAL_INTERVAL, hwb_pkg::CFG_MAX_INTERVAL,
               hwb_pkg::CFG_REPLY_TIMEOUT};
    for (int i = 0; i < 3; i++) begin
      cfg_we    = 1'b1;
      cfg_idx   = idxs[i];
      cfg_wdata = values[i];
      tracker.write_reg(idxs[i], values[i]);
      @(negedge clk);
    end
    cfg_we = 1'b0;
  endtask

  // One random phase: settle, reprogram, set the pressure, stream requests.
  // Halfway through, hold the sender until the result queue is empty.
  task automatic run_phase(input logic [hwb_pkg::CFG_W-1:0] first_ticks,
                           input logic [hwb_pkg::CFG_W-1:0] top_ticks,
                           input logic [hwb_pkg::CFG_W-1:0] wait_ticks,
                           input int unsigned idle_pct, input int unsigned stall,
                           input int unsigned count);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    program_regs(first_ticks, top_ticks, wait_ticks);
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    for (int unsigned i = 0; i < count; i++) begin
      if (i == count / 2)
        wait_drained();
      send_req(random_req());
    end
  endtask

  initial begin
    tracker                     = new();
    rst_n                       = 1'b0;
    cfg_we                      = 1'b0;
    cfg_idx                     = hwb_pkg::CFG_INITIAL_INTERVAL;
    cfg_wdata                   = '0;
    in_chan.valid               = 1'b0;
    in_chan.cmd                 = hwb_pkg::CMD_TICK;
    in_chan.should_be_active    = 1'b0;
    in_chan.partner_suspended   = 1'b0;
    in_chan.may_go_unresponsive = 1'b0;

    // Hold reset, release on a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed opener with one-tick intervals and a ceiling of four
    program_regs(16'd1, 16'd4, 16'd1);
    // Arm, then deactivate while armed: interval drops to initial
    send_req(make_req(hwb_pkg::CMD_UPDATE, 1'b1, 1'b1, 1'b1));
    send_req(make_req(hwb_pkg::CMD_UPDATE, 1'b0, 1'b1, 1'b1));
    send_req(make_req(hwb_pkg::CMD_UPDATE, 1'b1, 1'b0, 1'b0));
    // Ping, then a timeout the client forbids from reporting
    send_req(make_req(hwb_pkg::CMD_TICK, 1'b0, 1'b0, 1'b0));
    send_req(make_req(hwb_pkg::CMD_TICK, 1'b0, 1'b0, 1'b0));
    // Count down once, ping, then a timeout suppressed by suspension
    send_req(make_req(hwb_pkg::CMD_TICK, 1'b1, 1'b1, 1'b1));
    send_req(make_req(hwb_pkg::CMD_TICK, 1'b1, 1'b1, 1'b1));
    send_req(make_req(hwb_pkg::CMD_TICK, 1'b0, 1'b1, 1'b1));
    // Reset the interval and rearm, ping, timeout that drops the flag
    send_req(make_req(hwb_pkg::CMD_UPDATE, 1'b0, 1'b0, 1'b0));
    send_req(make_req(hwb_pkg::CMD_UPDATE, 1'b1, 1'b0, 1'b0));
    send_req(make_req(hwb_pkg::CMD_TICK, 1'b0, 1'b0, 1'b1));
    send_req(make_req(hwb_pkg::CMD_TICK, 1'b0, 1'b0, 1'b1));
    // Ping again and answer it: flag comes back with a notice
    send_req(make_req(hwb_pkg::CMD_TICK, 1'b0, 1'b0, 1'b0));
    send_req(make_req(hwb_pkg::CMD_TICK, 1'b0, 1'b0, 1'b0));
    send_req(make_req(hwb_pkg::CMD_PONG, 1'b1, 1'b1, 1'b1));
    // Active update while the check runs is ignored
    send_req(make_req(hwb_pkg::CMD_UPDATE, 1'b1, 1'b1, 1'b1));
    // Run out the saturated interval, ping, drop the flag again
    repeat (4) send_req(make_req(hwb_pkg::CMD_TICK, 1'b1, 1'b0, 1'b0));
    send_req(make_req(hwb_pkg::CMD_TICK, 1'b1, 1'b0, 1'b1));
    // Teardown with a notice, then stray commands and unused codes
    send_req(make_req(hwb_pkg::CMD_TERMINATED, 1'b1, 1'b1, 1'b1));
    send_req(make_req(hwb_pkg::CMD_INVALIDATE, 1'b0, 1'b0, 1'b0));
    send_req(make_req(hwb_pkg::CMD_PONG, 1'b0, 1'b0, 1'b0));
    send_req(make_req(hwb_pkg::CMD_TICK, 1'b1, 1'b1, 1'b1));
    send_req(make_req(3'd5, 1'b1, 1'b1, 1'b1));
    send_req(make_req(3'd7, 1'b1, 1'b1, 1'b1));

    // Random phases across settings and handshake pressure
    run_phase(16'd2, 16'd16, 16'd3, 0, 0, 120);
    run_phase(16'd1, 16'd1, 16'd1, 60, 0, 80);
    run_phase(16'd5, 16'd65535, 16'd4, 0, 60, 120);
    run_phase(16'd65535, 16'd65535, 16'd65535, 31, 31, 30);
    run_phase(16'd100, 16'd6, 16'd2, 31, 31, 120);
    run_phase(16'd3, 16'd50, 16'd5, 0, 0, 80);

    // Drain and let the pipeline settle before the verdict
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// ===== heartbeat_watchdog_backoff_unit.f =====
hw/rtl/hwb_pkg.sv
hw/rtl/hwb_if.sv
hw/rtl/hwb_core.sv
hw/rtl/heartbeat_watchdog_backoff_unit.sv
hw/rtl/hwb_checker.sv
bench/heartbeat_watchdog_backoff_unit_test.sv
